@@ hw/rtl/lls_pkg.sv @@
package lls_pkg;

   localparam int CmdBits     = 3;
   localparam int ElemBits    = 32;
   localparam int StatBits    = 2;
   localparam int CountBits   = 5;
   localparam int CfgBits     = 5;
   localparam int DefDepth    = 16;
   localparam int DefWordBits = 32;

   localparam logic [CfgBits-1:0] CapacityReset = 5'd16;

   localparam logic [CmdBits-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CmdBits-1:0] CMD_POP    = 3'd1;
   localparam logic [CmdBits-1:0] CMD_TOP    = 3'd2;
   localparam logic [CmdBits-1:0] CMD_FIND   = 3'd3;
   localparam logic [CmdBits-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CmdBits-1:0] CMD_CLEAR  = 3'd5;

   localparam logic [StatBits-1:0] STAT_OK        = 2'd0;
   localparam logic [StatBits-1:0] STAT_FULL      = 2'd1;
   localparam logic [StatBits-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [StatBits-1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [CmdBits-1:0]  command;
      logic [ElemBits-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [ElemBits-1:0]  read_value;
      logic                 found;
      logic [StatBits-1:0]  status;
      logic [CountBits-1:0] entry_count;
      logic                 is_full;
      logic                 is_empty;
   } rsp_type;

endpackage

@@ hw/rtl/lls_ram.sv @@
module lls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lls_ctrl.sv @@
module lls_ctrl #(
   parameter int DEPTH     = lls_pkg::DefDepth,
   parameter int WORD_BITS = lls_pkg::DefWordBits
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lls_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lls_pkg::rsp_type           rsp_data,
   input  logic [$clog2(DEPTH+1)-1:0] cap_eff,
   output logic                       ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
   output logic [WORD_BITS-1:0]       ram_wr_data,
   output logic                       ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
   input  logic [WORD_BITS-1:0]       ram_rd_data
);

   import lls_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TOP    = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_SHIFT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [WORD_BITS-1:0] key_ff, key_in;
   logic                 remove_ff, remove_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 out_free;
   logic                 accept;
   logic                 hit;
   logic                 finish;
   logic [WORD_BITS-1:0] word;
   logic [CW-1:0]        idx_p1;
   logic [CW-1:0]        idx_p2;
   logic [CW-1:0]        cnt_m1;
   logic [CW-1:0]        fin_cnt;
   logic [ElemBits-1:0]  fin_read;
   logic                 fin_found;
   logic [StatBits-1:0]  fin_status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign word      = WORD_BITS'(req_data.element_value);
   assign idx_p1    = CW'(idx_ff) + CW'(1);
   assign idx_p2    = idx_p1 + CW'(1);
   assign cnt_m1    = cnt_ff - CW'(1);
   assign hit       = (ram_rd_data == key_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      remove_in    = remove_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_p1[AW-1:0];
      finish       = 1'b0;
      fin_cnt      = cnt_ff;
      fin_read     = '0;
      fin_found    = 1'b0;
      fin_status   = STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_PUSH: begin
                     if (cnt_ff >= cap_eff) begin
                        fin_status = STAT_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cnt_ff[AW-1:0];
                        ram_wr_data = word;
                        fin_cnt     = cnt_ff + CW'(1);
                     end
                     finish = 1'b1;
                  end
                  CMD_POP: begin
                     if (cnt_ff == '0) begin
                        fin_status = STAT_EMPTY;
                     end else begin
                        fin_cnt = cnt_m1;
                     end
                     finish = 1'b1;
                  end
                  CMD_TOP: begin
                     if (cnt_ff == '0) begin
                        fin_status = STAT_EMPTY;
                        finish     = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cnt_m1[AW-1:0];
                        cnt_in      = cnt_m1;
                        state_in    = ST_TOP;
                     end
                  end
                  CMD_FIND, CMD_REMOVE: begin
                     if (cnt_ff == '0) begin
                        fin_status = STAT_NOT_FOUND;
                        finish     = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        key_in      = word;
                        remove_in   = (req_data.command == CMD_REMOVE);
                        state_in    = ST_SEARCH;
                     end
                  end
                  CMD_CLEAR: begin
                     fin_cnt = '0;
                     finish  = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_TOP: begin
            if (out_free) begin
               fin_read = ElemBits'(ram_rd_data);
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            priority if (hit && remove_ff && (idx_p1 < cnt_ff)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_p1[AW-1:0];
               state_in    = ST_SHIFT;
            end else if (hit) begin
               if (out_free) begin
                  fin_found = 1'b1;
                  fin_cnt   = remove_ff ? cnt_m1 : cnt_ff;
                  finish    = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (idx_p1 == cnt_ff) begin
               if (out_free) begin
                  fin_status = STAT_NOT_FOUND;
                  finish     = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_p1[AW-1:0];
               idx_in      = idx_p1[AW-1:0];
            end
         end
         ST_SHIFT: begin
            if (idx_p1 < cnt_m1) begin
               ram_wr_en   = 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_p2[AW-1:0];
               idx_in      = idx_p1[AW-1:0];
            end else if (out_free) begin
               ram_wr_en = 1'b1;
               fin_found = 1'b1;
               fin_cnt   = cnt_m1;
               finish    = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         cnt_in              = fin_cnt;
         rsp_valid_in        = 1'b1;
         rsp_in.read_value   = fin_read;
         rsp_in.found        = fin_found;
         rsp_in.status       = fin_status;
         rsp_in.entry_count  = CountBits'(fin_cnt);
         rsp_in.is_full      = (fin_cnt >= cap_eff);
         rsp_in.is_empty     = (fin_cnt == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      remove_ff <= remove_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/searchable_lifo_stack.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | lls_pkg::req_type
// rsp     | out       | rsp_valid, rsp_stall | lls_pkg::rsp_type
// csr     | in        | csr_write            | capacity
//
// Push, pop, clear and unknown commands finish in the idle state; top waits for a registered RAM read.
// Find and remove scan one entry per cycle through the single read port of the entry RAM,
// remove shifting one entry per cycle after the match.
// Synchronous active-high reset empties the stack and sets capacity to 16.
// req_stall stays high while a command is in progress or a result waits on rsp_stall.
module searchable_lifo_stack #(
   parameter int DEPTH     = lls_pkg::DefDepth,
   parameter int WORD_BITS = lls_pkg::DefWordBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lls_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lls_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [lls_pkg::CfgBits-1:0]   csr_wdata
);

   import lls_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CapW = (CW > CfgBits) ? CW : CfgBits;

   logic [CfgBits-1:0]   cap_ff, cap_in;
   logic [CapW-1:0]      cap_wide;
   logic [CW-1:0]        cap_eff;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 req_accept;

   assign cap_in   = csr_write ? csr_wdata : cap_ff;
   assign cap_wide = CapW'(cap_ff);

   always_comb begin
      priority if (cap_wide == '0) begin
         cap_eff = CW'(1);
      end else if (cap_wide > CapW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = cap_wide[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapacityReset;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lls_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lls_ctrl #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cap_eff     (cap_eff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   assign req_accept = req_valid && !req_stall;

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.command == CMD_PUSH || req_data.command == CMD_POP ||
                     req_data.command == CMD_CLEAR) |=> rsp_valid)
      else $error("single-cycle command gave no result");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.command == CMD_CLEAR |=>
         rsp_data.entry_count == '0 && rsp_data.is_empty && rsp_data.status == STAT_OK)
      else $error("clear left entries");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == STAT_OK && rsp_data.read_value == '0)
      else $error("found result with bad status or data");

endmodule

@@ bench/searchable_lifo_stack_test.sv @@
`timescale 1ns / 100ps

module searchable_lifo_stack_test;
   import lls_pkg::*;

   localparam logic [CmdBits-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CmdBits-1:0] CMD_SPARE_HI = 3'd7;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_AFTER  = 150;
   localparam int unsigned TAIL_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CfgBits-1:0] csr_wdata = CapacityReset;

   req_type pending_items[$];
   rsp_type pending_results[$];
   rsp_type predicted;

   logic [ElemBits-1:0] stack_words[DefDepth];
   int unsigned word_count = 0;
   logic [CfgBits-1:0] capacity_reg = CapacityReset;

   logic req_taken = 1'b0;
   int unsigned queued_items = 0;
   int unsigned accepted_items = 0;
   int unsigned results_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned settings_used = 0;
   int unsigned full_refusals = 0;
   int unsigned empty_refusals = 0;
   int unsigned misses = 0;
   int unsigned removals = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;

   searchable_lifo_stack i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type apply_command(req_type item);
      rsp_type result;
      int unsigned limit;
      int unsigned pos;
      int unsigned i;
      bit hit;
      result = '0;
      hit = 1'b0;
      pos = 0;
      if (capacity_reg == 0) begin
         limit = 1;
      end else if (capacity_reg > DefDepth) begin
         limit = DefDepth;
      end else begin
         limit = capacity_reg;
      end
      case (item.command)
         CMD_PUSH: begin
            if (word_count >= limit) begin
               result.status = STAT_FULL;
            end else begin
               stack_words[word_count] = item.element_value;
               word_count++;
            end
         end
         CMD_POP: begin
            if (word_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               word_count--;
            end
         end
         CMD_TOP: begin
            if (word_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               word_count--;
               result.read_value = stack_words[word_count];
            end
         end
         CMD_FIND, CMD_REMOVE: begin
            for (i = 0; i < word_count; i++) begin
               if (!hit && stack_words[i] == item.element_value) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
            if (!hit) begin
               result.status = STAT_NOT_FOUND;
            end else begin
               result.found = 1'b1;
               if (item.command == CMD_REMOVE) begin
                  for (i = pos; i + 1 < word_count; i++) begin
                     stack_words[i] = stack_words[i + 1];
                  end
                  word_count--;
               end
            end
         end
         CMD_CLEAR: begin
            word_count = 0;
         end
         default: begin
         end
      endcase
      result.entry_count = word_count[CountBits-1:0];
      result.is_full = (word_count >= limit);
      result.is_empty = (word_count == 0);
      return result;
   endfunction

   task automatic report_field(string name, logic [ElemBits-1:0] want, logic [ElemBits-1:0] got);
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      fail_count++;
   endtask

   task automatic check_result(rsp_type got, rsp_type want);
      if (got.read_value !== want.read_value)
         report_field("read_value", want.read_value, got.read_value);
      if (got.found !== want.found)
         report_field("found", ElemBits'(want.found), ElemBits'(got.found));
      if (got.status !== want.status)
         report_field("status", ElemBits'(want.status), ElemBits'(got.status));
      if (got.entry_count !== want.entry_count)
         report_field("entry_count", ElemBits'(want.entry_count), ElemBits'(got.entry_count));
      if (got.is_full !== want.is_full)
         report_field("is_full", ElemBits'(want.is_full), ElemBits'(got.is_full));
      if (got.is_empty !== want.is_empty)
         report_field("is_empty", ElemBits'(want.is_empty), ElemBits'(got.is_empty));
   endtask

   // monitor: check results, predict accepted items, track capacity writes
   always @(posedge clock) begin
      if (reset) begin
         word_count = 0;
         capacity_reg = CapacityReset;
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: expected none, got %h", $time, rsp_data);
               fail_count++;
            end else begin
               check_result(rsp_data, pending_results.pop_front());
            end
         end
         if (csr_write) begin
            capacity_reg = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            predicted = apply_command(req_data);
            if (predicted.status == STAT_FULL) full_refusals++;
            if (predicted.status == STAT_EMPTY) empty_refusals++;
            if (predicted.status == STAT_NOT_FOUND) misses++;
            if (predicted.found && req_data.command == CMD_REMOVE) removals++;
            pending_results.push_back(predicted);
            accepted_items++;
         end
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // driver: hold the item until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, plus one long hold to back up the input side
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic queue_command(logic [CmdBits-1:0] cmd, logic [ElemBits-1:0] value);
      req_type item;
      item.command = cmd;
      item.element_value = value;
      pending_items.push_back(item);
      queued_items++;
   endtask

   task automatic drain_items();
      @(negedge clock);
      while (accepted_items != queued_items || pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(logic [CfgBits-1:0] value);
      drain_items();
      csr_wdata <= value;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(logic [CfgBits-1:0] cap, int unsigned sender_pct,
                             int unsigned receiver_pct, int unsigned push_pct,
                             int unsigned count);
      logic [ElemBits-1:0] pool[8];
      logic [ElemBits-1:0] value;
      logic [CmdBits-1:0] cmd;
      int unsigned n;
      int unsigned burst;
      int unsigned roll;
      write_capacity(cap);
      @(posedge clock);
      idle_pct = sender_pct;
      stall_pct = receiver_pct;
      pool[0] = '0;
      pool[1] = '1;
      for (n = 2; n < 8; n++) pool[n] = $urandom;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            burst = $urandom_range(16, 4);
            repeat (burst) queue_command(CMD_PUSH, pool[$urandom_range(7)]);
            n += burst;
         end else begin
            value = ($urandom_range(99) < 70) ? pool[$urandom_range(7)] : $urandom;
            roll = $urandom_range(99);
            if ($urandom_range(99) < push_pct) begin
               cmd = CMD_PUSH;
            end else if (roll < 18) begin
               cmd = CMD_POP;
            end else if (roll < 38) begin
               cmd = CMD_TOP;
            end else if (roll < 63) begin
               cmd = CMD_FIND;
            end else if (roll < 88) begin
               cmd = CMD_REMOVE;
            end else if (roll < 94) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end
            queue_command(cmd, value);
            n++;
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      queue_command(CMD_POP, 32'h0000_0000);
      queue_command(CMD_TOP, 32'h0000_0000);
      queue_command(CMD_FIND, 32'h0000_0000);
      queue_command(CMD_REMOVE, 32'h0000_0005);
      queue_command(CMD_PUSH, 32'h0000_0000);
      queue_command(CMD_PUSH, 32'hFFFF_FFFF);
      queue_command(CMD_PUSH, 32'h1234_5678);
      queue_command(CMD_PUSH, 32'h0000_0000);
      queue_command(CMD_FIND, 32'h0000_0000);
      queue_command(CMD_FIND, 32'hDEAD_BEEF);
      queue_command(CMD_REMOVE, 32'h0000_0000);
      queue_command(CMD_TOP, 32'h0000_0000);
      queue_command(CMD_SPARE_LO, 32'hFFFF_FFFF);
      queue_command(CMD_SPARE_HI, 32'h0000_0000);
      queue_command(CMD_TOP, 32'h0000_0000);
      queue_command(CMD_CLEAR, 32'h0000_0000);

      write_capacity(5'd2);
      @(posedge clock);
      queue_command(CMD_PUSH, 32'hA5A5_A5A5);
      queue_command(CMD_PUSH, 32'h5A5A_5A5A);
      queue_command(CMD_PUSH, 32'h0000_0001);

      // shrink below the count: stays full, entries kept
      write_capacity(5'd1);
      @(posedge clock);
      queue_command(CMD_PUSH, 32'h0000_0002);
      queue_command(CMD_FIND, 32'h5A5A_5A5A);
      queue_command(CMD_TOP, 32'h0000_0000);

      write_capacity(5'd0);
      @(posedge clock);
      queue_command(CMD_PUSH, 32'h0000_0003);
      queue_command(CMD_POP, 32'h0000_0000);
      queue_command(CMD_PUSH, 32'h0000_0003);

      run_random(5'd16, 0, 0, 45, 120);
      run_random(5'd4, 56, 0, 40, 120);
      run_random(5'd31, 0, 56, 50, 120);
      run_random(5'd1, 20, 20, 40, 80);
      run_random(5'd0, 56, 0, 40, 60);
      run_random(5'd9, 20, 20, 45, 100);
      run_random(5'd16, 0, 0, 50, 100);

      drain_items();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t %0d results never arrived", $time, pending_results.size());
         fail_count++;
      end
      $display("checked %0d commands under %0d capacity writes, %0d mismatches",
               accepted_items, settings_used, fail_count);
      $display("seen %0d full refusals, %0d empty refusals, %0d misses, %0d removals",
               full_refusals, empty_refusals, misses, removals);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
